// ===== rtl/core/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared widths, codes and structs of the sprite frame sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

	// item fields
	localparam int CMD_W     = 2;
	localparam int SLOT_W    = 6;
	localparam int FVAL_W    = 10;
	localparam int ELAPSED_W = 16;

	// result fields
	localparam int FNUM_W = 10;
	localparam int SRCX_W = 12;
	localparam int SRCY_W = 16;
	localparam int SRCX_MAX = 4095;
	localparam int SRCY_MAX = 65535;

	// configuration
	localparam int COUNT_W  = 7;
	localparam int DELAY_W  = 16;
	localparam int REPEAT_W = 9;
	localparam int PIX_W    = 13;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	localparam int MIN_ANIMATED = 2;

	// serial arithmetic units
	localparam int STEP_W = 6;
	localparam int SUM_W  = ELAPSED_W + 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE   = 2'd0,
		CMD_TICK    = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		REG_FRAME_COUNT  = 3'd0,
		REG_FRAME_DELAY  = 3'd1,
		REG_REPEAT_LIMIT = 3'd2,
		REG_CELL_WIDTH   = 3'd3,
		REG_CELL_HEIGHT  = 3'd4,
		REG_SHEET_WIDTH  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  frame_count;
		logic [DELAY_W-1:0]  frame_delay;
		logic [REPEAT_W-1:0] repeat_limit;   // two's complement, all ones = endless
		logic [PIX_W-1:0]    cell_width;
		logic [PIX_W-1:0]    cell_height;
		logic [PIX_W-1:0]    sheet_width;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} unit_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/sfs_regs.sv =====
// ----------------------------------------------------------------------------
// sfs_regs
// APB register bank holding the animation and sheet geometry settings.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sfs_pkg::PADDR_W-1:0]  paddr,
	input  logic [sfs_pkg::PDATA_W-1:0]  pwdata,
	output logic [sfs_pkg::PDATA_W-1:0]  prdata,
	output sfs_pkg::cfg_t                cfg
);
	import sfs_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_count  <= COUNT_W'(1);
			cfg_q.frame_delay  <= DELAY_W'(1);
			cfg_q.repeat_limit <= '1;
			cfg_q.cell_width   <= PIX_W'(16);
			cfg_q.cell_height  <= PIX_W'(16);
			cfg_q.sheet_width  <= PIX_W'(256);
		end else if (wr_en) begin
			case (reg_idx)
				REG_FRAME_COUNT:  cfg_q.frame_count  <= pwdata[COUNT_W-1:0];
				REG_FRAME_DELAY:  cfg_q.frame_delay  <= pwdata[DELAY_W-1:0];
				REG_REPEAT_LIMIT: cfg_q.repeat_limit <= pwdata[REPEAT_W-1:0];
				REG_CELL_WIDTH:   cfg_q.cell_width   <= pwdata[PIX_W-1:0];
				REG_CELL_HEIGHT:  cfg_q.cell_height  <= pwdata[PIX_W-1:0];
				REG_SHEET_WIDTH:  cfg_q.sheet_width  <= pwdata[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FRAME_COUNT:  prdata = PDATA_W'(cfg_q.frame_count);
			REG_FRAME_DELAY:  prdata = PDATA_W'(cfg_q.frame_delay);
			REG_REPEAT_LIMIT: prdata = PDATA_W'(cfg_q.repeat_limit);
			REG_CELL_WIDTH:   prdata = PDATA_W'(cfg_q.cell_width);
			REG_CELL_HEIGHT:  prdata = PDATA_W'(cfg_q.cell_height);
			REG_SHEET_WIDTH:  prdata = PDATA_W'(cfg_q.sheet_width);
			default:          prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/sfs_sdiv.sv =====
// ----------------------------------------------------------------------------
// sfs_sdiv
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_sdiv #(
	parameter int NW = 18,
	parameter int DW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sfs_pkg::unit_ctl_t   ctl,
	input  logic [NW-1:0]        num,
	input  logic [DW-1:0]        den,
	output sfs_pkg::unit_sts_t   sts,
	output logic [NW-1:0]        quo,
	output logic [DW-1:0]        rem
);
	import sfs_pkg::*;

	logic [NW-1:0]     quo_q;
	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     den_q;
	logic [STEP_W-1:0] cnt_q;
	logic              done_q;
	logic [DW:0]       trial;
	logic [DW:0]       diff;
	logic              fits;

	// numerator is left-aligned at start so only ctl.steps bits are walked
	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				quo_q <= num << (NW - int'(ctl.steps));
				rem_q <= '0;
				den_q <= den;
				cnt_q <= ctl.steps;
			end else if (cnt_q != '0) begin
				rem_q  <= fits ? diff[DW-1:0] : trial[DW-1:0];
				quo_q  <= {quo_q[NW-2:0], fits};
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == STEP_W'(1));
			end
		end
	end

	assign sts.busy = (cnt_q != '0);
	assign sts.done = done_q;
	assign quo      = quo_q;
	assign rem      = rem_q;

endmodule

`default_nettype wire

// ===== rtl/core/sfs_smul.sv =====
// ----------------------------------------------------------------------------
// sfs_smul
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_smul #(
	parameter int A_W = 17,
	parameter int B_W = 13
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sfs_pkg::unit_ctl_t   ctl,
	input  logic [A_W-1:0]       a,
	input  logic [B_W-1:0]       b,
	output sfs_pkg::unit_sts_t   sts,
	output logic [A_W+B_W-1:0]   prod
);
	import sfs_pkg::*;

	localparam int PW = A_W + B_W;

	logic [A_W-1:0]    a_q;
	logic [B_W-1:0]    b_q;
	logic [PW-1:0]     acc_q;
	logic [STEP_W-1:0] cnt_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			acc_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				a_q   <= a;
				b_q   <= b << (B_W - int'(ctl.steps));
				acc_q <= '0;
				cnt_q <= ctl.steps;
			end else if (cnt_q != '0) begin
				acc_q  <= {acc_q[PW-2:0], 1'b0} + (b_q[B_W-1] ? PW'(a_q) : PW'(0));
				b_q    <= {b_q[B_W-2:0], 1'b0};
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == STEP_W'(1));
			end
		end
	end

	assign sts.busy = (cnt_q != '0);
	assign sts.done = done_q;
	assign prod     = acc_q;

endmodule

`default_nettype wire

// ===== rtl/core/sprite_frame_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_core
// Frame table, timer and repeat sequencing for one animated sprite.
// ----------------------------------------------------------------------------
// A table write gives no result. A restart, a tick on a held animation or a
// tick on a single-frame animation goes straight to the table read; a normal
// tick first runs the timer division, and the wrap division as well when the
// slot wraps past the frame count. The work is done by the shared bit-serial
// divider and multiplier (one bit per cycle) that work out the timer, the wrap
// count and the sheet coordinates in turn. One item is in work at a time; a
// finished result waits in the output register while the next item is taken.
// Table entries must be written before they are shown.
`default_nettype none

module sprite_frame_sequencer_core #(
	parameter int TABLE_DEPTH = 64,
	parameter int FRAME_BITS  = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [sfs_pkg::CMD_W-1:0]      command,
	input  logic [sfs_pkg::SLOT_W-1:0]     slot,
	input  logic [sfs_pkg::FVAL_W-1:0]     frame_value,
	input  logic [sfs_pkg::ELAPSED_W-1:0]  elapsed,

	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [sfs_pkg::FNUM_W-1:0]     frame_number,
	output logic [sfs_pkg::SLOT_W-1:0]     frame_slot,
	output logic [sfs_pkg::SRCX_W-1:0]     source_x,
	output logic [sfs_pkg::SRCY_W-1:0]     source_y,
	output logic                           done_res,

	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sfs_pkg::PADDR_W-1:0]    paddr,
	input  logic [sfs_pkg::PDATA_W-1:0]    pwdata,
	output logic [sfs_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);
	import sfs_pkg::*;

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int SS_W  = SUM_W + 1;
	localparam int POS_W = FRAME_BITS + PIX_W;
	localparam int NW    = (POS_W > SS_W) ? POS_W : SS_W;
	localparam int BW    = (FRAME_BITS > PIX_W) ? FRAME_BITS : PIX_W;
	localparam int MA_W  = SRCY_W + 1;
	localparam int PW    = MA_W + BW;
	localparam int RW    = SS_W + 2;

	localparam logic [STEP_W-1:0] TICK_STEPS  = STEP_W'(SUM_W);
	localparam logic [STEP_W-1:0] WRAP_STEPS  = STEP_W'(SS_W);
	localparam logic [STEP_W-1:0] POS_STEPS   = STEP_W'(POS_W);
	localparam logic [STEP_W-1:0] FRAME_STEPS = STEP_W'(FRAME_BITS);
	localparam logic [STEP_W-1:0] CELL_STEPS  = STEP_W'(PIX_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_T,
		ST_DIV_W,
		ST_READ,
		ST_MUL_P,
		ST_DIV_S,
		ST_MUL_Y,
		ST_OUT
	} state_t;

	cfg_t cfg;

	state_t                state_q;
	logic [DELAY_W-1:0]    residue_q;
	logic [AW-1:0]         cur_slot_q;
	logic [AW-1:0]         rd_slot_q;
	logic [REPEAT_W-1:0]   repeats_q;
	logic                  finished_q;
	logic                  done_flag_q;
	logic [ELAPSED_W-1:0]  elapsed_q;
	logic [SS_W-1:0]       slot_sum_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic [SRCX_W-1:0]     x_q;
	logic [SRCY_W-1:0]     y_q;
	logic                  div_start_q;
	logic                  mul_start_q;

	logic                  res_valid_q;
	logic [FNUM_W-1:0]     frame_number_q;
	logic [SLOT_W-1:0]     frame_slot_q;
	logic [SRCX_W-1:0]     source_x_q;
	logic [SRCY_W-1:0]     source_y_q;
	logic                  done_res_q;

	logic [FRAME_BITS-1:0] table_mem [TABLE_DEPTH];
	logic [FRAME_BITS-1:0] rdata_q;
	logic                  tbl_we;

	unit_ctl_t             div_ctl;
	unit_sts_t             div_sts;
	logic [NW-1:0]         div_num;
	logic [DELAY_W-1:0]    div_den;
	logic [NW-1:0]         div_quo;
	logic [DELAY_W-1:0]    div_rem;

	unit_ctl_t             mul_ctl;
	unit_sts_t             mul_sts;
	logic [MA_W-1:0]       mul_a;
	logic [BW-1:0]         mul_b;
	logic [PW-1:0]         mul_prod;

	logic [COUNT_W-1:0]    count_eff;
	logic [DELAY_W-1:0]    delay_eff;
	logic [PIX_W-1:0]      sw_eff;
	logic [SUM_W-1:0]      time_sum;
	logic [SS_W-1:0]       slot_sum;
	logic signed [RW-1:0]  rep_left;
	logic                  endless;
	logic                  out_free;
	logic                  res_load;
	logic                  div_go;
	logic                  mul_go;
	logic [MA_W-1:0]       q_sat;
	logic [SRCX_W-1:0]     x_sat;
	logic [SRCY_W-1:0]     y_sat;

	sfs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// effective settings: zero values, and a frame count above the table depth, are clamped
	always_comb begin
		count_eff = cfg.frame_count;
		if (cfg.frame_count == '0)
			count_eff = COUNT_W'(1);
		else if (int'(cfg.frame_count) > TABLE_DEPTH)
			count_eff = COUNT_W'(TABLE_DEPTH);
	end

	assign delay_eff = (cfg.frame_delay == '0) ? DELAY_W'(1) : cfg.frame_delay;
	assign sw_eff    = (cfg.sheet_width == '0) ? PIX_W'(1) : cfg.sheet_width;

	assign time_sum = SUM_W'(residue_q) + SUM_W'(elapsed_q);
	assign slot_sum = SS_W'(cur_slot_q) + SS_W'(div_quo[SUM_W-1:0]);
	assign endless  = (repeats_q == '1);
	assign rep_left = $signed({{(RW-REPEAT_W){repeats_q[REPEAT_W-1]}}, repeats_q})
		- $signed({2'b00, div_quo[SS_W-1:0]});

	// any row above the 16-bit range saturates y unless cell height is zero
	assign q_sat = (div_quo > NW'(SRCY_MAX)) ? (MA_W'(SRCY_MAX) + MA_W'(1)) : MA_W'(div_quo);
	assign x_sat = (div_rem > DELAY_W'(SRCX_MAX)) ? SRCX_W'(SRCX_MAX) : div_rem[SRCX_W-1:0];
	assign y_sat = (mul_prod > PW'(SRCY_MAX)) ? SRCY_W'(SRCY_MAX) : mul_prod[SRCY_W-1:0];

	always_comb begin
		div_ctl.start = div_start_q;
		div_ctl.steps = POS_STEPS;
		div_num       = NW'(mul_prod);
		div_den       = DELAY_W'(sw_eff);
		case (state_q)
			ST_DIV_T: begin
				div_ctl.steps = TICK_STEPS;
				div_num       = NW'(time_sum);
				div_den       = delay_eff;
			end
			ST_DIV_W: begin
				div_ctl.steps = WRAP_STEPS;
				div_num       = NW'(slot_sum_q);
				div_den       = DELAY_W'(count_eff);
			end
			default: ;
		endcase
	end

	always_comb begin
		mul_ctl.start = mul_start_q;
		if (state_q == ST_MUL_P) begin
			mul_ctl.steps = FRAME_STEPS;
			mul_a         = MA_W'(cfg.cell_width);
			mul_b         = BW'(rdata_q);
		end else begin
			mul_ctl.steps = CELL_STEPS;
			mul_a         = q_sat;
			mul_b         = BW'(cfg.cell_height);
		end
	end

	sfs_sdiv #(
		.NW (NW),
		.DW (DELAY_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (div_num),
		.den    (div_den),
		.sts    (div_sts),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	sfs_smul #(
		.A_W (MA_W),
		.B_W (BW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.a      (mul_a),
		.b      (mul_b),
		.sts    (mul_sts),
		.prod   (mul_prod)
	);

	assign item_stall = (state_q != ST_IDLE);
	assign tbl_we     = item_valid && !item_stall && (command == CMD_WRITE)
		&& (int'(slot) < TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (tbl_we)
			table_mem[AW'(slot)] <= FRAME_BITS'(frame_value);
		rdata_q <= table_mem[rd_slot_q];
	end

	assign out_free = !res_valid_q || !res_stall;
	assign res_load = (state_q == ST_OUT) && out_free;

	// start pulses for the serial units, registered so each is high in the first cycle of the state that needs it
	assign div_go = ((state_q == ST_IDLE) && item_valid && (command == CMD_TICK)
			&& !finished_q && (count_eff >= COUNT_W'(MIN_ANIMATED)))
		|| ((state_q == ST_DIV_T) && div_sts.done && (slot_sum >= SS_W'(count_eff)))
		|| ((state_q == ST_MUL_P) && mul_sts.done);
	assign mul_go = (state_q == ST_READ) || ((state_q == ST_DIV_S) && div_sts.done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			residue_q      <= '0;
			cur_slot_q     <= '0;
			rd_slot_q      <= '0;
			repeats_q      <= '1;
			finished_q     <= 1'b0;
			done_flag_q    <= 1'b0;
			elapsed_q      <= '0;
			slot_sum_q     <= '0;
			frame_q        <= '0;
			x_q            <= '0;
			y_q            <= '0;
			div_start_q    <= 1'b0;
			mul_start_q    <= 1'b0;
			res_valid_q    <= 1'b0;
			frame_number_q <= '0;
			frame_slot_q   <= '0;
			source_x_q     <= '0;
			source_y_q     <= '0;
			done_res_q     <= 1'b0;
		end else begin
			div_start_q <= div_go;
			mul_start_q <= mul_go;
			res_valid_q <= res_load || (res_valid_q && res_stall);

			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						elapsed_q <= elapsed;
						case (command)
							CMD_RESTART: begin
								cur_slot_q  <= '0;
								residue_q   <= '0;
								finished_q  <= 1'b0;
								repeats_q   <= cfg.repeat_limit;
								rd_slot_q   <= '0;
								done_flag_q <= 1'b0;
								state_q     <= ST_READ;
							end
							CMD_TICK: begin
								if (finished_q) begin
									rd_slot_q   <= cur_slot_q;
									done_flag_q <= 1'b1;
									state_q     <= ST_READ;
								end else if (count_eff < COUNT_W'(MIN_ANIMATED)) begin
									rd_slot_q   <= '0;
									done_flag_q <= 1'b0;
									state_q     <= ST_READ;
								end else begin
									state_q     <= ST_DIV_T;
								end
							end
							default: ;
						endcase
					end
				end
				ST_DIV_T: begin
					if (div_sts.done) begin
						residue_q  <= div_rem;
						slot_sum_q <= slot_sum;
						if (slot_sum >= SS_W'(count_eff)) begin
							state_q     <= ST_DIV_W;
						end else begin
							cur_slot_q  <= AW'(slot_sum);
							rd_slot_q   <= AW'(slot_sum);
							done_flag_q <= 1'b0;
							state_q     <= ST_READ;
						end
					end
				end
				ST_DIV_W: begin
					// quotient is the number of wraps, remainder the new slot
					if (div_sts.done) begin
						if (!endless && (rep_left[RW-1] || (rep_left == '0))) begin
							repeats_q   <= '0;
							finished_q  <= 1'b1;
							residue_q   <= '0;
							cur_slot_q  <= AW'(count_eff - COUNT_W'(1));
							rd_slot_q   <= AW'(count_eff - COUNT_W'(1));
							done_flag_q <= 1'b1;
						end else begin
							if (!endless)
								repeats_q <= REPEAT_W'(rep_left);
							cur_slot_q  <= AW'(div_rem);
							rd_slot_q   <= AW'(div_rem);
							done_flag_q <= 1'b0;
						end
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_MUL_P;
				end
				ST_MUL_P: begin
					if (mul_start_q)
						frame_q <= rdata_q;
					if (mul_sts.done)
						state_q <= ST_DIV_S;
				end
				ST_DIV_S: begin
					if (div_sts.done) begin
						x_q     <= x_sat;
						state_q <= ST_MUL_Y;
					end
				end
				ST_MUL_Y: begin
					if (mul_sts.done) begin
						y_q     <= y_sat;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						frame_number_q <= FNUM_W'(frame_q);
						frame_slot_q   <= SLOT_W'(rd_slot_q);
						source_x_q     <= x_q;
						source_y_q     <= y_q;
						done_res_q     <= done_flag_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid    = res_valid_q;
	assign frame_number = frame_number_q;
	assign frame_slot   = frame_slot_q;
	assign source_x     = source_x_q;
	assign source_y     = source_y_q;
	assign done_res     = done_res_q;

	a_held_no_repeats: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> (repeats_q == '0))
		else $error("held animation with repeats left");

	a_div_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |-> !div_sts.busy)
		else $error("divider started while busy");

	a_unit_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		(div_sts.done || mul_sts.done) |-> (state_q != ST_IDLE && state_q != ST_OUT))
		else $error("arithmetic unit finished outside a wait state");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result loaded outside the output state");

endmodule

`default_nettype wire
